FILE: sv/bpa_pkg.sv
package bpa_pkg;
   localparam int NUM_PAGES_DEF = 4096;
   localparam int TOP_ORDER_DEF = 12;
   localparam logic CMD_ALLOC = 1'b0;
   localparam logic CMD_FREE  = 1'b1;
   localparam logic ST_OK   = 1'b0;
   localparam logic ST_FAIL = 1'b1;
endpackage

FILE: sv/bpa_if.sv
interface bpa_req_if;
   logic        valid;
   logic        ready;
   logic        command;
   logic [31:0] size_bytes;
   logic [11:0] page_index;
   modport source (output valid, command, size_bytes, page_index, input ready);
   modport sink   (input valid, command, size_bytes, page_index, output ready);
endinterface

interface bpa_rsp_if;
   logic        valid;
   logic        ready;
   logic        status;
   logic [11:0] result_page;
   logic [3:0]  result_order;
   modport source (output valid, status, result_page, result_order, input ready);
   modport sink   (input valid, status, result_page, result_order, output ready);
endinterface

FILE: sv/bpa_ram.sv
module bpa_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);
   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   // one write port, one registered read port
   always_ff @(posedge clock) begin
      if (we) mem[waddr] <= wdata;
      rdata_ff <= mem[raddr];
   end
   assign rdata = rdata_ff;
endmodule

FILE: sv/buddy_page_allocator_unit.sv
// Alloc: up to 29 size doublings, a probe of the free lists from the wanted order up, then
// unlink and splits; free: range check, free-bit (double free) check, then merges.
// Requests: one at a time, paced by the sequencer walking lists and buddies; a stalled
// result blocks only the last step.
// Reset: synchronous active high; all pages allocated at order 0, all lists empty, then a
// clearing pass of the page state memory during which no request is accepted.
module buddy_page_allocator_unit import bpa_pkg::*; #(
   parameter int NUM_PAGES = NUM_PAGES_DEF,
   parameter int TOP_ORDER = TOP_ORDER_DEF
) (
   input  logic         clock,
   input  logic         reset,
   bpa_req_if.sink      req,
   bpa_rsp_if.source    rsp,
   input  logic         csr_we,
   input  logic [12:0]  csr_wdata
);
   localparam int AW = $clog2(NUM_PAGES);
   localparam int LW = AW + 1;            // link width, NIL = NUM_PAGES
   localparam int OW = $clog2(TOP_ORDER + 1);
   localparam int SW = 5;                 // state code width
   localparam logic [LW-1:0] NIL = LW'(NUM_PAGES);
   localparam logic [OW-1:0] TOPO = OW'(TOP_ORDER);

   localparam logic [SW-1:0] S_CLR = 5'd0, S_IDLE = 5'd1, S_ROUND = 5'd2,
      S_SCAN = 5'd3, S_POP = 5'd4, S_UL_RD = 5'd5, S_UL_W1 = 5'd6,
      S_UL_RD2 = 5'd7, S_UL_W2 = 5'd8, S_SPLIT = 5'd9, S_PUSH0 = 5'd10,
      S_PUSH1 = 5'd11, S_PUSH2 = 5'd12, S_FR_RD = 5'd13, S_FR_CK = 5'd14,
      S_BD_RD = 5'd15, S_BD_CK = 5'd16, S_RESP = 5'd17, S_DONE = 5'd18,
      S_AFTER = 5'd19, S_FR_WAIT = 5'd20, S_BD_WAIT = 5'd21;

   logic [SW-1:0] state_ff, state_in, ret_ff, ret_in;
   logic [12:0]   pool_ff;
   logic [LW-1:0] head_ff [TOP_ORDER+1];
   logic [LW-1:0] head_in [TOP_ORDER+1];
   logic          cmd_ff;
   logic [31:0]   size_ff;
   logic [33:0]   rnd_ff, rnd_in;
   logic [OW-1:0] want_ff, want_in, ord_ff, ord_in;
   logic [AW-1:0] blk_ff, blk_in, idx_ff, idx_in;
   logic [LW-1:0] nx_ff, nx_in, pv_ff, pv_in;
   logic          st_ff, st_in, ovalid_ff, ovalid_in;
   logic [AW:0]   clr_ff, clr_in;
   logic          out_st_ff;
   logic [11:0]   out_page_ff;
   logic [3:0]    out_order_ff;

   // page state memory {free, order}; link memory {next, prev}
   logic          pw_we, lw_we;
   logic [AW-1:0] pw_a, pr_a, lw_a, lr_a;
   logic [OW:0]   pw_d, pr_d;
   logic [2*LW-1:0] lw_d, lr_d;

   bpa_ram #(.WIDTH(OW+1), .DEPTH(NUM_PAGES)) u_page (.clock, .we(pw_we),
      .waddr(pw_a), .wdata(pw_d), .raddr(pr_a), .rdata(pr_d));
   bpa_ram #(.WIDTH(2*LW), .DEPTH(NUM_PAGES)) u_link (.clock, .we(lw_we),
      .waddr(lw_a), .wdata(lw_d), .raddr(lr_a), .rdata(lr_d));

   logic [13:0] lim;
   logic [AW:0] span, bud_end;
   logic [AW-1:0] bud;
   assign lim  = (14'(pool_ff) < 14'(NUM_PAGES)) ? 14'(pool_ff) : 14'(NUM_PAGES);
   assign span = (AW+1)'(1) << ord_ff;
   assign bud  = idx_ff ^ span[AW-1:0];
   assign bud_end = {1'b0, bud} + span;

   assign req.ready = (state_ff == S_IDLE);
   assign rsp.valid = ovalid_ff;
   assign rsp.status = out_st_ff;
   assign rsp.result_page = out_page_ff;
   assign rsp.result_order = out_order_ff;

   // sequencer
   always_comb begin
      state_in = state_ff; ret_in = ret_ff; head_in = head_ff;
      rnd_in = rnd_ff; want_in = want_ff; ord_in = ord_ff; blk_in = blk_ff;
      idx_in = idx_ff; nx_in = nx_ff; pv_in = pv_ff; st_in = st_ff;
      ovalid_in = ovalid_ff; clr_in = clr_ff;
      pw_we = 1'b0; pw_a = '0; pw_d = '0; pr_a = idx_ff;
      lw_we = 1'b0; lw_a = '0; lw_d = '0; lr_a = idx_ff;
      if (ovalid_ff && rsp.ready) ovalid_in = 1'b0;
      unique case (state_ff)
         S_CLR: begin
            pw_we = 1'b1; pw_a = clr_ff[AW-1:0];
            clr_in = clr_ff + 1'b1;
            if (clr_ff == (AW+1)'(NUM_PAGES - 1)) state_in = S_IDLE;
         end
         S_IDLE: if (req.valid) begin
            rnd_in = 34'd8; want_in = '0; st_in = ST_OK;
            idx_in = AW'(req.page_index);
            state_in = (req.command == CMD_ALLOC) ? S_ROUND : S_FR_RD;
         end
         // one doubling per cycle; order counted alongside
         S_ROUND: begin
            if (rnd_ff < 34'(size_ff)) begin
               rnd_in = rnd_ff << 1;
               if (rnd_ff >= 34'(32'd4096) && want_ff != TOPO + 1'b1)
                  want_in = want_ff + 1'b1;
            end else if (rnd_ff > (34'd1 << (TOP_ORDER + 12))) begin
               st_in = ST_FAIL; state_in = S_DONE;
            end else begin
               ord_in = want_ff; state_in = S_SCAN;
            end
         end
         S_SCAN: begin
            if (head_ff[ord_ff] != NIL) begin
               blk_in = head_ff[ord_ff][AW-1:0]; state_in = S_POP;
            end else if (ord_ff == TOPO) begin
               st_in = ST_FAIL; state_in = S_DONE;
            end else ord_in = ord_ff + 1'b1;
         end
         S_POP: begin
            idx_in = blk_ff; ret_in = S_SPLIT; state_in = S_UL_RD;
            pw_we = 1'b1; pw_a = blk_ff; pw_d = {1'b0, ord_ff};
         end
         // unlink idx_ff from list ord_ff
         S_UL_RD: begin lr_a = idx_ff; state_in = S_UL_W1; end
         S_UL_W1: begin
            nx_in = lr_d[2*LW-1:LW]; pv_in = lr_d[LW-1:0];
            if (lr_d[LW-1:0] != NIL) begin
               lr_a = lr_d[AW-1:0]; state_in = S_UL_RD2;
            end else begin
               head_in[ord_ff] = lr_d[2*LW-1:LW]; state_in = S_UL_W2;
            end
         end
         // hold the predecessor address so its links arrive in S_AFTER
         S_UL_RD2: begin lr_a = pv_ff[AW-1:0]; state_in = S_AFTER; end
         S_AFTER: begin
            lw_we = 1'b1; lw_a = pv_ff[AW-1:0]; lw_d = {nx_ff, lr_d[LW-1:0]};
            state_in = S_UL_W2; lr_a = nx_ff[AW-1:0];
         end
         S_UL_W2: begin
            lr_a = nx_ff[AW-1:0];
            if (nx_ff != NIL) begin state_in = S_BD_WAIT; end
            else state_in = ret_ff;
         end
         S_BD_WAIT: begin
            lw_we = 1'b1; lw_a = nx_ff[AW-1:0]; lw_d = {lr_d[2*LW-1:LW], pv_ff};
            state_in = ret_ff;
         end
         // split: push right half at lower order
         S_SPLIT: begin
            if (ord_ff == want_ff) begin
               pw_we = 1'b1; pw_a = blk_ff; pw_d = {1'b0, ord_ff};
               state_in = S_DONE;
            end else begin
               ord_in = ord_ff - 1'b1;
               idx_in = blk_ff + AW'((AW+1)'(1) << (ord_ff - 1'b1));
               ret_in = S_SPLIT; state_in = S_PUSH0;
            end
         end
         S_PUSH0: begin
            pw_we = 1'b1; pw_a = idx_ff; pw_d = {1'b1, ord_ff};
            lw_we = 1'b1; lw_a = idx_ff; lw_d = {head_ff[ord_ff], NIL};
            nx_in = head_ff[ord_ff]; lr_a = head_ff[ord_ff][AW-1:0];
            head_in[ord_ff] = {1'b0, idx_ff};
            state_in = (head_ff[ord_ff] != NIL) ? S_PUSH1 : ret_ff;
         end
         S_PUSH1: begin lr_a = nx_ff[AW-1:0]; state_in = S_PUSH2; end
         S_PUSH2: begin
            lw_we = 1'b1; lw_a = nx_ff[AW-1:0];
            lw_d = {lr_d[2*LW-1:LW], 1'b0, idx_ff};
            state_in = ret_ff;
         end
         // free: check range and free bit
         S_FR_RD: begin
            if (14'(idx_ff) >= lim) begin st_in = ST_FAIL; state_in = S_DONE; end
            else state_in = S_FR_WAIT;
         end
         S_FR_WAIT: state_in = S_FR_CK;
         S_FR_CK: begin
            if (pr_d[OW]) begin st_in = ST_FAIL; state_in = S_DONE; end
            else begin
               ord_in = (pr_d[OW-1:0] > TOPO) ? TOPO : pr_d[OW-1:0];
               blk_in = idx_ff; state_in = S_BD_RD;
            end
         end
         S_BD_RD: begin
            pr_a = bud;
            if (ord_ff == TOPO || 14'(bud_end) > lim) begin
               idx_in = blk_ff; ret_in = S_RESP; state_in = S_PUSH0;
            end else state_in = S_BD_CK;
         end
         S_BD_CK: begin
            if (!pr_d[OW] || pr_d[OW-1:0] != ord_ff) begin
               idx_in = blk_ff; ret_in = S_RESP; state_in = S_PUSH0;
            end else begin
               pw_we = 1'b1; pw_a = blk_ff ^ span[AW-1:0]; pw_d = {1'b0, ord_ff};
               idx_in = blk_ff ^ span[AW-1:0]; ret_in = S_RESP; state_in = S_UL_RD;
            end
         end
         S_RESP: begin
            // after unlink of buddy, or after final push
            if (idx_ff != blk_ff) begin
               if (idx_ff < blk_ff) blk_in = idx_ff;
               idx_in = (idx_ff < blk_ff) ? idx_ff : blk_ff;
               ord_in = ord_ff + 1'b1; state_in = S_BD_RD;
            end else state_in = S_DONE;
         end
         S_DONE: if (!ovalid_ff || rsp.ready) begin
            ovalid_in = 1'b1; state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
      // free path: keep merged start in idx for buddy computation
      if (state_ff == S_RESP && idx_ff != blk_ff) idx_in = (idx_ff < blk_ff) ? idx_ff : blk_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLR; clr_ff <= '0; ovalid_ff <= 1'b0; pool_ff <= 13'd4096;
         for (int i = 0; i <= TOP_ORDER; i++) head_ff[i] <= NIL;
      end else begin
         state_ff <= state_in; clr_ff <= clr_in; ovalid_ff <= ovalid_in;
         head_ff <= head_in;
         if (csr_we) pool_ff <= csr_wdata;
      end
      ret_ff <= ret_in; rnd_ff <= rnd_in; want_ff <= want_in; ord_ff <= ord_in;
      blk_ff <= blk_in; idx_ff <= idx_in; nx_ff <= nx_in; pv_ff <= pv_in;
      st_ff <= st_in;
      if (state_ff == S_IDLE) begin
         cmd_ff <= req.command; size_ff <= req.size_bytes;
      end
      // result beat held here while it waits, so the next request can start
      if (state_ff == S_DONE && (!ovalid_ff || rsp.ready)) begin
         out_st_ff <= st_ff;
         out_page_ff <= st_ff ? 12'd0 : 12'(blk_ff);
         out_order_ff <= st_ff ? 4'd0 : 4'(ord_ff);
      end
   end

`ifndef SYNTHESIS
   a_ready_idle: assert property (@(posedge clock) disable iff (reset)
      req.ready |-> !ovalid_ff || state_ff == S_IDLE) else $error("ready");
   a_fail_zero: assert property (@(posedge clock) disable iff (reset)
      rsp.valid && rsp.status |-> rsp.result_order == 4'd0) else $error("fail");
   a_order_max: assert property (@(posedge clock) disable iff (reset)
      rsp.valid |-> rsp.result_order <= 4'(TOP_ORDER)) else $error("order");
   a_accept_leaves: assert property (@(posedge clock) disable iff (reset)
      req.valid && req.ready |=> state_ff != S_IDLE) else $error("accept");
   a_cmd_used: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_ROUND |-> cmd_ff == CMD_ALLOC) else $error("cmd");
`endif
endmodule

FILE: test/buddy_page_allocator_unit_test.sv
module buddy_page_allocator_unit_test import bpa_pkg::*; ();
   timeunit 1ns;
   timeprecision 1ps;

   localparam int PAGES = NUM_PAGES_DEF;
   localparam int TOP   = TOP_ORDER_DEF;
   localparam int NIL   = PAGES;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        csr_we = 1'b0;
   logic [12:0] csr_wdata = 13'd0;

   bpa_req_if req ();
   bpa_rsp_if rsp ();

   buddy_page_allocator_unit uut (
      .clock(clock), .reset(reset), .req(req), .rsp(rsp),
      .csr_we(csr_we), .csr_wdata(csr_wdata)
   );

   always #5 clock = ~clock;

   typedef struct packed {
      logic        status;
      logic [11:0] page;
      logic [3:0]  order;
   } alloc_result_type;

   // Shadow allocator state
   logic [3:0] shadow_order [PAGES];
   bit         shadow_free  [PAGES];
   int         link_next    [PAGES];
   int         link_prev    [PAGES];
   int         free_head    [TOP+1];
   int         pool_size;

   alloc_result_type pending_results[$];
   int  errors = 0;
   int  beats_sent = 0;
   int  beats_checked = 0;
   int  allocs_ok = 0;
   int  merges_seen = 0;
   bit  calm = 1'b0;

   function automatic int usable_pages();
      return (pool_size < PAGES) ? pool_size : PAGES;
   endfunction

   function automatic void push_block(int n, int o);
      int h;
      h = free_head[o];
      link_next[n] = h;
      link_prev[n] = NIL;
      if (h < NIL) link_prev[h] = n;
      free_head[o] = n;
   endfunction

   function automatic void unlink_block(int n, int o);
      int p, x;
      p = link_prev[n];
      x = link_next[n];
      if (p < NIL) link_next[p] = x;
      else free_head[o] = x;
      if (x < NIL) link_prev[x] = p;
   endfunction

   function automatic alloc_result_type predict_alloc(logic [31:0] size);
      alloc_result_type r;
      longint unsigned rounded, pages;
      int want, o, blk, right;
      r = '0;
      r.status = ST_FAIL;
      rounded = 8;
      want = 0;
      while (rounded < {32'd0, size}) rounded = rounded << 1;
      if (rounded > (64'd1 << (TOP + 12))) return r;
      pages = rounded >> 12;
      while ((64'd1 << want) < pages) want++;
      for (o = want; o <= TOP; o++)
         if (free_head[o] < NIL) break;
      if (o > TOP) return r;
      blk = free_head[o];
      unlink_block(blk, o);
      shadow_free[blk] = 1'b0;
      shadow_order[blk] = o[3:0];
      while (o > want) begin
         o--;
         right = blk + (1 << o);
         shadow_order[blk] = o[3:0];
         if (right < NIL) begin
            shadow_order[right] = o[3:0];
            shadow_free[right] = 1'b1;
            push_block(right, o);
         end
      end
      r.status = ST_OK;
      r.page = blk[11:0];
      r.order = o[3:0];
      return r;
   endfunction

   function automatic alloc_result_type predict_free(logic [11:0] page);
      alloc_result_type r;
      int lim, idx, o, span, bud;
      r = '0;
      r.status = ST_FAIL;
      lim = usable_pages();
      idx = page;
      if (idx >= lim || shadow_free[idx]) return r;
      o = shadow_order[idx];
      if (o > TOP) o = TOP;
      while (o < TOP) begin
         span = 1 << o;
         bud = idx ^ span;
         if (bud + span > lim) break;
         if (!shadow_free[bud] || shadow_order[bud] != o) break;
         unlink_block(bud, o);
         shadow_free[bud] = 1'b0;
         if (bud < idx) idx = bud;
         o++;
         merges_seen++;
      end
      shadow_order[idx] = o[3:0];
      shadow_free[idx] = 1'b1;
      push_block(idx, o);
      r.status = ST_OK;
      r.page = idx[11:0];
      r.order = o[3:0];
      return r;
   endfunction

   function automatic bit take_pause();
      return !calm && ($urandom_range(0, 99) < 33);
   endfunction

   // Result side: random back-pressure and in-order compare
   always @(posedge clock) begin
      alloc_result_type want;
      if (reset) begin
         rsp.ready <= 1'b0;
      end else begin
         if (rsp.valid && rsp.ready) begin
            if (pending_results.size() == 0) begin
               $error("unexpected result beat: status %0d page %0d order %0d",
                      rsp.status, rsp.result_page, rsp.result_order);
               errors++;
            end else begin
               want = pending_results.pop_front();
               beats_checked++;
               if (rsp.status !== want.status) begin
                  $error("status: expected %0d, got %0d", want.status, rsp.status);
                  errors++;
               end
               if (rsp.result_page !== want.page) begin
                  $error("result_page: expected %0d, got %0d", want.page, rsp.result_page);
                  errors++;
               end
               if (rsp.result_order !== want.order) begin
                  $error("result_order: expected %0d, got %0d", want.order,
                         rsp.result_order);
                  errors++;
               end
            end
         end
         rsp.ready <= !take_pause();
      end
   end

   // One request beat; the prediction is made when the beat is accepted
   task automatic send_request(input logic cmd, input logic [31:0] size,
                               input logic [11:0] page, input bit typed,
                               input alloc_result_type typed_result,
                               output alloc_result_type got);
      while (take_pause()) begin
         req.valid <= 1'b0;
         @(posedge clock);
      end
      req.valid <= 1'b1;
      req.command <= cmd;
      req.size_bytes <= size;
      req.page_index <= page;
      @(posedge clock);
      while (!req.ready) @(posedge clock);
      got = (cmd == CMD_ALLOC) ? predict_alloc(size) : predict_free(page);
      if (typed) got = typed_result;
      pending_results.push_back(got);
      beats_sent++;
   endtask

   task automatic drain_results();
      req.valid <= 1'b0;
      @(posedge clock);
      while (pending_results.size() != 0) @(posedge clock);
      repeat (200) @(posedge clock);
   endtask

   task automatic write_pool(input int value);
      drain_results();
      @(posedge clock);
      csr_we <= 1'b1;
      csr_wdata <= value[12:0];
      @(posedge clock);
      csr_we <= 1'b0;
      pool_size = value & 13'h1FFF;
   endtask

   typedef struct {
      logic             cmd;
      logic [31:0]      size;
      logic [11:0]      page;
      bit               typed;
      alloc_result_type res;
   } stim_row_type;

   localparam alloc_result_type REJECT = '{status: ST_FAIL, page: 12'd0, order: 4'd0};
   localparam alloc_result_type NONE   = '0;

   stim_row_type directed[$];
   logic [11:0] held_blocks[$];

   initial begin
      alloc_result_type got;
      int fresh_next, pick, k, n, phase;
      int pools[5];
      logic [31:0] size;
      logic [11:0] page;

      req.valid = 1'b0;
      req.command = CMD_ALLOC;
      req.size_bytes = '0;
      req.page_index = '0;
      pool_size = PAGES;
      for (int i = 0; i < PAGES; i++) begin
         shadow_order[i] = '0;
         shadow_free[i] = 1'b0;
         link_next[i] = 0;
         link_prev[i] = 0;
      end
      for (int o = 0; o <= TOP; o++) free_head[o] = NIL;

      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // Directed: small pool, corner cases, fill it page by page, then more corner cases
      write_pool(16);
      directed.push_back('{CMD_ALLOC, 32'd4096, 12'd0, 1, REJECT});   // nothing free yet
      directed.push_back('{CMD_FREE, 32'd0, 12'd16, 1, REJECT});      // beyond pool
      directed.push_back('{CMD_FREE, 32'hFFFFFFFF, 12'd4095, 1, REJECT});
      for (int p = 0; p < 16; p++)
         directed.push_back('{CMD_FREE, 32'd0, p[11:0], 0, NONE});
      directed.push_back('{CMD_FREE, 32'd0, 12'd0, 1, REJECT});       // double free
      directed.push_back('{CMD_ALLOC, 32'hFFFFFFFF, 12'd0, 1, REJECT}); // too large
      directed.push_back('{CMD_ALLOC, 32'd16777217, 12'd0, 1, REJECT});
      directed.push_back('{CMD_ALLOC, 32'd16777216, 12'd0, 1, REJECT}); // order 12, none
      directed.push_back('{CMD_ALLOC, 32'd0, 12'hFFF, 0, NONE});
      directed.push_back('{CMD_ALLOC, 32'd8193, 12'd0, 0, NONE});
      directed.push_back('{CMD_FREE, 32'd0, 12'd5, 0, NONE});         // interior page
      foreach (directed[i])
         send_request(directed[i].cmd, directed[i].size, directed[i].page,
                      directed[i].typed, directed[i].res, got);

      // Random phases over several pool sizes
      pools = '{PAGES, 1, 64, $urandom_range(2, PAGES - 1), PAGES};
      fresh_next = 16;
      for (phase = 0; phase < 5; phase++) begin
         write_pool(pools[phase]);
         for (n = 0; n < 180; n++) begin
            calm = (phase == 2 && n >= 40 && n < 140);
            if (phase == 3 && n == 90) drain_results();   // let the block run dry
            pick = $urandom_range(0, 99);
            if (pick < 38) begin
               k = $urandom_range(0, 7);
               size = (k == 7) ? $urandom() : $urandom_range(0, 4096 << k);
               send_request(CMD_ALLOC, size, 12'($urandom()), 0, NONE, got);
               if (got.status == ST_OK) begin
                  held_blocks.push_back(got.page);
                  allocs_ok++;
               end
            end else if (pick < 88) begin
               if (held_blocks.size() > 0 && (pick < 65 || fresh_next >= PAGES)) begin
                  k = $urandom_range(0, held_blocks.size() - 1);
                  page = held_blocks[k];
                  held_blocks.delete(k);
               end else begin
                  page = fresh_next[11:0];
                  fresh_next = (fresh_next < PAGES) ? fresh_next + 1 : fresh_next;
               end
               send_request(CMD_FREE, $urandom(), page, 0, NONE, got);
            end else begin
               // noise: arbitrary page, often a double or interior free
               send_request(CMD_FREE, $urandom(), 12'($urandom()), 0, NONE, got);
            end
         end
      end
      calm = 1'b0;

      drain_results();
      $display("Covered %0d request beats, %0d checked, %0d allocations, %0d merges,",
               beats_sent, beats_checked, allocs_ok, merges_seen);
      $display("over pool sizes 16, 1, 64, %0d and the full pool.", pools[3]);
      if (errors == 0 && pending_results.size() == 0)
         $display("PASSED: all results match");
      else
         $display("FAILED: results differ");
      $finish;
   end

   initial begin
      #20ms;
      $display("FAILED: results differ");
      $finish;
   end
endmodule
